@@ sv/ttcmr_pkg.sv @@
// Types, constants and small helpers for the median-ratio time-to-collision block.
// No dependencies; used by every module of the block.
package ttcmr_pkg;

    localparam int unsigned COORD_W    = 16;
    localparam int unsigned RATIO_W    = 24;
    localparam int unsigned TTC_W      = 40;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned PERIOD_W   = 20;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 20;
    localparam int unsigned SQ_W       = 32;
    localparam int unsigned SUM_W      = 33;
    localparam int unsigned DIV_W      = 48;
    localparam int unsigned MAG_W      = 37;
    localparam int unsigned DIV_STEPS  = 48;
    localparam int unsigned SQRT_STEPS = 24;
    localparam int unsigned BIT_IDX_W  = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MINDIST = 2'd1;

    localparam logic [PERIOD_W-1:0] PERIOD_RST  = 20'd100000;
    localparam logic [COORD_W-1:0]  MINDIST_RST = 16'd1600;

    localparam logic [RATIO_W-1:0] ONE_Q16   = 24'h010000;
    localparam logic [RATIO_W-1:0] RATIO_MAX = 24'hFFFFFF;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ONE  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_SAT  = 2'd3;

    typedef struct packed {
        logic [COORD_W-1:0] prev_x;
        logic [COORD_W-1:0] prev_y;
        logic [COORD_W-1:0] curr_x;
        logic [COORD_W-1:0] curr_y;
        logic               last_match;
    } t_in;

    typedef struct packed {
        logic signed [TTC_W-1:0] ttc_us;
        logic [RATIO_W-1:0]      median_ratio;
        logic [STATUS_W-1:0]     status;
    } t_out;

    typedef enum logic [4:0] {
        S_IDLE, S_PINIT, S_RDI, S_LATI, S_RDJ, S_LATJ, S_SQ, S_SUM, S_CHK,
        S_DIV, S_SQRT, S_STORE, S_NEXT, S_MINIT, S_SINIT, S_SCAN, S_SBIT,
        S_MED, S_TINIT, S_TDIV, S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic pinit;
        logic rd_i;
        logic lat_i;
        logic rd_j;
        logic lat_j;
        logic sq;
        logic sum;
        logic sat;
        logic div_ratio;
        logic sqrt_start;
        logic take_sqrt;
        logic store;
        logic next;
        logic minit;
        logic sinit;
        logic scan;
        logic sbit;
        logic med;
        logic div_ttc;
        logic take_ttc;
        logic out;
    } t_cmd;

    typedef struct packed {
        logic few_pts;
        logic keep;
        logic over;
        logic div_done;
        logic sqrt_done;
        logic j_more;
        logic i_more;
        logic r_zero;
        logic scan_done;
        logic bit_zero;
        logic second;
        logic med_one;
    } t_sts;

    function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                    input logic [COORD_W-1:0] b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

@@ sv/ttcmr_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on ttcmr_pkg.
module ttcmr_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [ttcmr_pkg::SUM_W-1:0]  i_rem,
    input  logic [ttcmr_pkg::DIV_W-1:0]  i_dvd,
    input  logic [ttcmr_pkg::SUM_W-1:0]  i_dvs,
    output logic                         o_done,
    output logic [ttcmr_pkg::DIV_W-1:0]  o_quo
);
    logic                        r_run;
    logic                        r_fin;
    logic [5:0]                  r_cnt;
    logic [ttcmr_pkg::SUM_W-1:0] r_rem;
    logic [ttcmr_pkg::DIV_W-1:0] r_dvd;
    logic [ttcmr_pkg::SUM_W-1:0] r_dvs;
    logic [ttcmr_pkg::DIV_W-1:0] r_quo;
    logic [ttcmr_pkg::SUM_W:0]   n_trial;
    logic                        n_ge;

    assign n_trial = {r_rem, r_dvd[ttcmr_pkg::DIV_W-1]};
    assign n_ge    = n_trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_fin <= 1'b0;
            r_cnt <= '0;
        end else if (i_start) begin
            r_run <= 1'b1;
            r_fin <= 1'b0;
            r_cnt <= '0;
        end else if (r_run) begin
            r_cnt <= r_cnt + 6'd1;
            if (r_cnt == 6'(ttcmr_pkg::DIV_STEPS - 1)) begin
                r_run <= 1'b0;
                r_fin <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_rem;
            r_dvd <= i_dvd;
            r_dvs <= i_dvs;
            r_quo <= '0;
        end else if (r_run) begin
            r_dvd <= {r_dvd[ttcmr_pkg::DIV_W-2:0], 1'b0};
            r_quo <= {r_quo[ttcmr_pkg::DIV_W-2:0], n_ge};
            if (n_ge) begin
                r_rem <= ttcmr_pkg::SUM_W'(n_trial - {1'b0, r_dvs});
            end else begin
                r_rem <= n_trial[ttcmr_pkg::SUM_W-1:0];
            end
        end
    end

    assign o_done = r_fin;
    assign o_quo  = r_quo;
endmodule

@@ sv/ttcmr_sqrt.sv @@
// Bit-pair integer square root of a 48-bit value, one result bit per cycle.
// Depends on ttcmr_pkg.
module ttcmr_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ttcmr_pkg::DIV_W-1:0]   i_val,
    output logic                          o_done,
    output logic [ttcmr_pkg::RATIO_W-1:0] o_root
);
    logic                        r_run;
    logic                        r_fin;
    logic [4:0]                  r_cnt;
    logic [ttcmr_pkg::DIV_W-1:0] r_n;
    logic [ttcmr_pkg::DIV_W-1:0] r_res;
    logic [ttcmr_pkg::DIV_W-1:0] r_bit;
    logic [ttcmr_pkg::DIV_W:0]   n_trial;

    assign n_trial = {1'b0, r_res} + {1'b0, r_bit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_fin <= 1'b0;
            r_cnt <= '0;
        end else if (i_start) begin
            r_run <= 1'b1;
            r_fin <= 1'b0;
            r_cnt <= '0;
        end else if (r_run) begin
            r_cnt <= r_cnt + 5'd1;
            if (r_cnt == 5'(ttcmr_pkg::SQRT_STEPS - 1)) begin
                r_run <= 1'b0;
                r_fin <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= i_val;
            r_res <= '0;
            r_bit <= ttcmr_pkg::DIV_W'(1) << (ttcmr_pkg::DIV_W - 2);
        end else if (r_run) begin
            r_bit <= r_bit >> 2;
            if ({1'b0, r_n} >= n_trial) begin
                r_n   <= ttcmr_pkg::DIV_W'({1'b0, r_n} - n_trial);
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
        end
    end

    assign o_done = r_fin;
    assign o_root = r_res[ttcmr_pkg::RATIO_W-1:0];
endmodule

@@ sv/ttcmr_ctrl.sv @@
// Sequencer: loads matches, walks pairs, runs median selection and the TTC divide.
// Depends on ttcmr_pkg.
module ttcmr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_last,
    input  ttcmr_pkg::t_sts   i_sts,
    output ttcmr_pkg::t_cmd   o_cmd,
    output logic              o_busy
);
    ttcmr_pkg::t_state r_state;
    ttcmr_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ttcmr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ttcmr_pkg::S_IDLE:  if (i_start && i_last) n_state = ttcmr_pkg::S_PINIT;
            ttcmr_pkg::S_PINIT: n_state = i_sts.few_pts ? ttcmr_pkg::S_MINIT : ttcmr_pkg::S_RDI;
            ttcmr_pkg::S_RDI:   n_state = ttcmr_pkg::S_LATI;
            ttcmr_pkg::S_LATI:  n_state = ttcmr_pkg::S_RDJ;
            ttcmr_pkg::S_RDJ:   n_state = ttcmr_pkg::S_LATJ;
            ttcmr_pkg::S_LATJ:  n_state = ttcmr_pkg::S_SQ;
            ttcmr_pkg::S_SQ:    n_state = ttcmr_pkg::S_SUM;
            ttcmr_pkg::S_SUM:   n_state = ttcmr_pkg::S_CHK;
            ttcmr_pkg::S_CHK: begin
                if (!i_sts.keep) n_state = ttcmr_pkg::S_NEXT;
                else if (i_sts.over) n_state = ttcmr_pkg::S_STORE;
                else n_state = ttcmr_pkg::S_DIV;
            end
            ttcmr_pkg::S_DIV:   if (i_sts.div_done) n_state = ttcmr_pkg::S_SQRT;
            ttcmr_pkg::S_SQRT:  if (i_sts.sqrt_done) n_state = ttcmr_pkg::S_STORE;
            ttcmr_pkg::S_STORE: n_state = ttcmr_pkg::S_NEXT;
            ttcmr_pkg::S_NEXT: begin
                if (i_sts.j_more) n_state = ttcmr_pkg::S_RDJ;
                else if (i_sts.i_more) n_state = ttcmr_pkg::S_RDI;
                else n_state = ttcmr_pkg::S_MINIT;
            end
            ttcmr_pkg::S_MINIT: n_state = i_sts.r_zero ? ttcmr_pkg::S_OUT : ttcmr_pkg::S_SINIT;
            ttcmr_pkg::S_SINIT: n_state = ttcmr_pkg::S_SCAN;
            ttcmr_pkg::S_SCAN:  if (i_sts.scan_done) n_state = ttcmr_pkg::S_SBIT;
            ttcmr_pkg::S_SBIT:  n_state = i_sts.bit_zero ? ttcmr_pkg::S_MED : ttcmr_pkg::S_SCAN;
            ttcmr_pkg::S_MED:   n_state = i_sts.second ? ttcmr_pkg::S_SINIT : ttcmr_pkg::S_TINIT;
            ttcmr_pkg::S_TINIT: n_state = i_sts.med_one ? ttcmr_pkg::S_OUT : ttcmr_pkg::S_TDIV;
            ttcmr_pkg::S_TDIV:  if (i_sts.div_done) n_state = ttcmr_pkg::S_OUT;
            ttcmr_pkg::S_OUT:   n_state = ttcmr_pkg::S_IDLE;
            default:            n_state = ttcmr_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            ttcmr_pkg::S_IDLE:  o_cmd.load  = i_start;
            ttcmr_pkg::S_PINIT: o_cmd.pinit = 1'b1;
            ttcmr_pkg::S_RDI:   o_cmd.rd_i  = 1'b1;
            ttcmr_pkg::S_LATI:  o_cmd.lat_i = 1'b1;
            ttcmr_pkg::S_RDJ:   o_cmd.rd_j  = 1'b1;
            ttcmr_pkg::S_LATJ:  o_cmd.lat_j = 1'b1;
            ttcmr_pkg::S_SQ:    o_cmd.sq    = 1'b1;
            ttcmr_pkg::S_SUM:   o_cmd.sum   = 1'b1;
            ttcmr_pkg::S_CHK: begin
                o_cmd.sat       = i_sts.keep && i_sts.over;
                o_cmd.div_ratio = i_sts.keep && !i_sts.over;
            end
            ttcmr_pkg::S_DIV:   o_cmd.sqrt_start = i_sts.div_done;
            ttcmr_pkg::S_SQRT:  o_cmd.take_sqrt  = i_sts.sqrt_done;
            ttcmr_pkg::S_STORE: o_cmd.store = 1'b1;
            ttcmr_pkg::S_NEXT:  o_cmd.next  = 1'b1;
            ttcmr_pkg::S_MINIT: o_cmd.minit = !i_sts.r_zero;
            ttcmr_pkg::S_SINIT: o_cmd.sinit = 1'b1;
            ttcmr_pkg::S_SCAN:  o_cmd.scan  = 1'b1;
            ttcmr_pkg::S_SBIT:  o_cmd.sbit  = 1'b1;
            ttcmr_pkg::S_MED:   o_cmd.med   = 1'b1;
            ttcmr_pkg::S_TINIT: o_cmd.div_ttc  = !i_sts.med_one;
            ttcmr_pkg::S_TDIV:  o_cmd.take_ttc = i_sts.div_done;
            ttcmr_pkg::S_OUT:   o_cmd.out   = 1'b1;
            default:            o_cmd = '0;
        endcase
    end

    assign o_busy = (r_state != ttcmr_pkg::S_IDLE);
endmodule

@@ sv/ttcmr_dp.sv @@
// Datapath: point and ratio memories, pair distances, radix median select, result.
// Depends on ttcmr_pkg, ttcmr_div and ttcmr_sqrt.
module ttcmr_dp #(
    parameter int unsigned MAX_MATCHES = 64,
    parameter int unsigned RATIO_DEPTH = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ttcmr_pkg::t_cmd                   i_cmd,
    output ttcmr_pkg::t_sts                   o_sts,
    input  ttcmr_pkg::t_in                    i_in,
    input  logic                              i_cfg_wr,
    input  logic [ttcmr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ttcmr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output ttcmr_pkg::t_out                   o_res,
    output logic                              o_res_valid
);
    localparam int unsigned MA_W = (MAX_MATCHES > 1) ? $clog2(MAX_MATCHES) : 1;
    localparam int unsigned MC_W = $clog2(MAX_MATCHES + 1);
    localparam int unsigned RA_W = $clog2(RATIO_DEPTH);
    localparam int unsigned RC_W = $clog2(RATIO_DEPTH + 1);
    localparam int unsigned PT_W = 4 * ttcmr_pkg::COORD_W;
    localparam int unsigned CW   = ttcmr_pkg::COORD_W;
    localparam int unsigned RW   = ttcmr_pkg::RATIO_W;

    logic [ttcmr_pkg::PERIOD_W-1:0] r_period;
    logic [CW-1:0]                  r_min_dist;

    logic [PT_W-1:0] mem_pt [MAX_MATCHES];
    logic [PT_W-1:0] r_pt_rd;
    logic [RW-1:0]   mem_ratio [RATIO_DEPTH];
    logic [RW-1:0]   r_ratio_rd;

    logic [MC_W-1:0] r_mcount;
    logic [MA_W-1:0] r_i;
    logic [MA_W-1:0] r_j;
    logic [PT_W-1:0] r_pi;
    logic [PT_W-1:0] r_pj;
    logic [ttcmr_pkg::SQ_W-1:0]  r_min_sq;
    logic [ttcmr_pkg::SQ_W-1:0]  r_dxp2, r_dyp2, r_dxc2, r_dyc2;
    logic [ttcmr_pkg::SUM_W-1:0] r_sp, r_sc;
    logic            r_sat;
    logic [RW-1:0]   r_ratio;
    logic [RC_W-1:0] r_rcount;

    logic            r_even;
    logic            r_second;
    logic [RC_W-1:0] r_k;
    logic [RC_W-1:0] r_addr;
    logic            r_rv;
    logic [RC_W-1:0] r_cnt;
    logic [RW-1:0]   r_prefix;
    logic [RW-1:0]   r_mask;
    logic [ttcmr_pkg::BIT_IDX_W-1:0] r_bit;
    logic [RW-1:0]   r_first;
    logic [RW-1:0]   r_med;
    logic [ttcmr_pkg::MAG_W-1:0] r_mag;

    ttcmr_pkg::t_out r_res;
    logic            r_res_valid;

    logic [MA_W-1:0]               n_pt_addr;
    logic                          n_match;
    logic [RW-1:0]                 n_d;
    logic [ttcmr_pkg::MAG_W-1:0]   n_num;
    logic                          div_start;
    logic [ttcmr_pkg::SUM_W-1:0]   div_rem;
    logic [ttcmr_pkg::DIV_W-1:0]   div_dvd;
    logic [ttcmr_pkg::SUM_W-1:0]   div_dvs;
    logic                          div_done;
    logic [ttcmr_pkg::DIV_W-1:0]   div_quo;
    logic                          sqrt_done;
    logic [RW-1:0]                 sqrt_root;
    logic [RW:0]                   n_sum2;
    ttcmr_pkg::t_out               n_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period   <= ttcmr_pkg::PERIOD_RST;
            r_min_dist <= ttcmr_pkg::MINDIST_RST;
        end else if (i_cfg_wr) begin
            if (i_cfg_index == ttcmr_pkg::CFG_PERIOD) begin
                r_period <= i_cfg_data[ttcmr_pkg::PERIOD_W-1:0];
            end else if (i_cfg_index == ttcmr_pkg::CFG_MINDIST) begin
                r_min_dist <= i_cfg_data[CW-1:0];
            end
        end
    end

    assign n_pt_addr = i_cmd.rd_i ? r_i : r_j;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (r_mcount < MC_W'(MAX_MATCHES))) begin
            mem_pt[r_mcount[MA_W-1:0]] <= {i_in.prev_x, i_in.prev_y, i_in.curr_x, i_in.curr_y};
        end
        if (i_cmd.rd_i || i_cmd.rd_j) begin
            r_pt_rd <= mem_pt[n_pt_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store && (r_rcount < RC_W'(RATIO_DEPTH))) begin
            mem_ratio[r_rcount[RA_W-1:0]] <= r_ratio;
        end
        if (i_cmd.scan && (r_addr < r_rcount)) begin
            r_ratio_rd <= mem_ratio[r_addr[RA_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mcount <= '0;
            r_rcount <= '0;
        end else begin
            if (i_cmd.load && (r_mcount < MC_W'(MAX_MATCHES))) begin
                r_mcount <= r_mcount + MC_W'(1);
            end else if (i_cmd.out) begin
                r_mcount <= '0;
            end
            if (i_cmd.pinit) begin
                r_rcount <= '0;
            end else if (i_cmd.store && (r_rcount < RC_W'(RATIO_DEPTH))) begin
                r_rcount <= r_rcount + RC_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pinit) begin
            r_i      <= '0;
            r_j      <= MA_W'(1);
            r_sat    <= 1'b0;
            r_min_sq <= r_min_dist * r_min_dist;
        end
        if (i_cmd.next) begin
            if (o_sts.j_more) begin
                r_j <= r_j + MA_W'(1);
            end else begin
                r_i <= r_i + MA_W'(1);
                r_j <= MA_W'(1);
            end
        end
        if (i_cmd.lat_i) r_pi <= r_pt_rd;
        if (i_cmd.lat_j) r_pj <= r_pt_rd;
        if (i_cmd.sq) begin
            r_dxp2 <= ttcmr_pkg::abs_diff(r_pi[4*CW-1:3*CW], r_pj[4*CW-1:3*CW])
                    * ttcmr_pkg::abs_diff(r_pi[4*CW-1:3*CW], r_pj[4*CW-1:3*CW]);
            r_dyp2 <= ttcmr_pkg::abs_diff(r_pi[3*CW-1:2*CW], r_pj[3*CW-1:2*CW])
                    * ttcmr_pkg::abs_diff(r_pi[3*CW-1:2*CW], r_pj[3*CW-1:2*CW]);
            r_dxc2 <= ttcmr_pkg::abs_diff(r_pi[2*CW-1:CW], r_pj[2*CW-1:CW])
                    * ttcmr_pkg::abs_diff(r_pi[2*CW-1:CW], r_pj[2*CW-1:CW]);
            r_dyc2 <= ttcmr_pkg::abs_diff(r_pi[CW-1:0], r_pj[CW-1:0])
                    * ttcmr_pkg::abs_diff(r_pi[CW-1:0], r_pj[CW-1:0]);
        end
        if (i_cmd.sum) begin
            r_sp <= {1'b0, r_dxp2} + {1'b0, r_dyp2};
            r_sc <= {1'b0, r_dxc2} + {1'b0, r_dyc2};
        end
        if (i_cmd.sat) begin
            r_sat   <= 1'b1;
            r_ratio <= ttcmr_pkg::RATIO_MAX;
        end
        if (i_cmd.take_sqrt) r_ratio <= sqrt_root;
    end

    assign n_match = (((r_ratio_rd ^ r_prefix) & r_mask) == '0) && !r_ratio_rd[r_bit];
    assign n_sum2  = {1'b0, r_first} + {1'b0, r_prefix};

    always_ff @(posedge i_clk) begin
        if (i_cmd.minit) begin
            r_even   <= ~r_rcount[0];
            r_second <= ~r_rcount[0];
            r_k      <= r_rcount[0] ? (r_rcount >> 1) : ((r_rcount >> 1) - RC_W'(1));
        end
        if (i_cmd.sinit) begin
            r_prefix <= '0;
            r_mask   <= '0;
            r_bit    <= ttcmr_pkg::BIT_IDX_W'(RW - 1);
        end
        if (i_cmd.sinit || i_cmd.sbit) begin
            r_addr <= '0;
            r_rv   <= 1'b0;
            r_cnt  <= '0;
        end else if (i_cmd.scan) begin
            r_rv <= (r_addr < r_rcount);
            if (r_addr < r_rcount) r_addr <= r_addr + RC_W'(1);
            if (r_rv && n_match) r_cnt <= r_cnt + RC_W'(1);
        end
        if (i_cmd.sbit) begin
            r_mask[r_bit] <= 1'b1;
            if (r_k >= r_cnt) begin
                r_prefix[r_bit] <= 1'b1;
                r_k             <= r_k - r_cnt;
            end
            if (r_bit != '0) r_bit <= r_bit - ttcmr_pkg::BIT_IDX_W'(1);
        end
        if (i_cmd.med) begin
            if (r_second) begin
                r_first  <= r_prefix;
                r_second <= 1'b0;
                r_k      <= r_rcount >> 1;
            end else if (r_even) begin
                r_med <= n_sum2[RW:1];
            end else begin
                r_med <= r_prefix;
            end
        end
        if (i_cmd.take_ttc) r_mag <= div_quo[ttcmr_pkg::MAG_W-1:0];
    end

    assign n_d   = (r_med > ttcmr_pkg::ONE_Q16) ? (r_med - ttcmr_pkg::ONE_Q16)
                                                : (ttcmr_pkg::ONE_Q16 - r_med);
    assign n_num = ttcmr_pkg::MAG_W'({r_period, 16'd0}) + ttcmr_pkg::MAG_W'(n_d >> 1);

    assign div_start = i_cmd.div_ratio || i_cmd.div_ttc;
    assign div_rem   = i_cmd.div_ttc ? '0 : ttcmr_pkg::SUM_W'(r_sc[ttcmr_pkg::SUM_W-1:16]);
    assign div_dvd   = i_cmd.div_ttc ? ttcmr_pkg::DIV_W'(n_num) : {r_sc[15:0], 32'd0};
    assign div_dvs   = i_cmd.div_ttc ? ttcmr_pkg::SUM_W'(n_d) : r_sp;

    ttcmr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_rem   (div_rem),
        .i_dvd   (div_dvd),
        .i_dvs   (div_dvs),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    ttcmr_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sqrt_start),
        .i_val   (div_quo),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    always_comb begin
        n_res = '0;
        if (r_rcount == '0) begin
            n_res.status = ttcmr_pkg::ST_NONE;
        end else if (r_med == ttcmr_pkg::ONE_Q16) begin
            n_res.status       = ttcmr_pkg::ST_ONE;
            n_res.median_ratio = r_med;
        end else begin
            n_res.status       = r_sat ? ttcmr_pkg::ST_SAT : ttcmr_pkg::ST_OK;
            n_res.median_ratio = r_med;
            n_res.ttc_us       = (r_med > ttcmr_pkg::ONE_Q16)
                               ? $signed(ttcmr_pkg::TTC_W'(r_mag))
                               : -$signed(ttcmr_pkg::TTC_W'(r_mag));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= i_cmd.out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out) r_res <= n_res;
    end

    assign o_sts.few_pts   = (r_mcount < MC_W'(2));
    assign o_sts.keep      = (r_sp != '0) && (r_sc >= ttcmr_pkg::SUM_W'(r_min_sq));
    assign o_sts.over      = ({r_sp, 16'd0} <= {16'd0, r_sc});
    assign o_sts.div_done  = div_done;
    assign o_sts.sqrt_done = sqrt_done;
    assign o_sts.j_more    = (MC_W'(r_j) + MC_W'(1)) < r_mcount;
    assign o_sts.i_more    = (MC_W'(r_i) + MC_W'(2)) < r_mcount;
    assign o_sts.r_zero    = (r_rcount == '0);
    assign o_sts.scan_done = (r_addr == r_rcount) && !r_rv;
    assign o_sts.bit_zero  = (r_bit == '0);
    assign o_sts.second    = r_second;
    assign o_sts.med_one   = (r_med == ttcmr_pkg::ONE_Q16);

    assign o_res       = r_res;
    assign o_res_valid = r_res_valid;
endmodule

@@ sv/camera_ttc_median_ratio_core.sv @@
// Median-ratio time to collision. A match that is not last is stored; busy stays low.
// The last match runs the set: each index pair is read, squared, summed and checked; a
// kept ratio takes a 48-step divide, 24-step square root and store, a clamped one a store;
// then 24 counting passes over the stored ratios (two rounds for an even count), then
// a 48-step divide unless the median is one. Result strobe 1 cycle as busy drops; no stall.
// Synchronous active-low reset clears control and config; no memory clearing pass.
module camera_ttc_median_ratio_core #(
    parameter int unsigned MAX_MATCHES = 64,
    parameter int unsigned RATIO_DEPTH = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  ttcmr_pkg::t_in                    i_in,
    output ttcmr_pkg::t_out                   o_res,
    output logic                              o_res_valid,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ttcmr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ttcmr_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    ttcmr_pkg::t_cmd cmd;
    ttcmr_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    ttcmr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_last  (i_in.last_match),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    ttcmr_dp #(
        .MAX_MATCHES (MAX_MATCHES),
        .RATIO_DEPTH (RATIO_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in        (i_in),
        .i_cfg_wr    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_res       (o_res),
        .o_res_valid (o_res_valid)
    );
endmodule

@@ sim/camera_ttc_median_ratio_core_test.sv @@
// Self-checking testbench for camera_ttc_median_ratio_core: keypoint sets in, TTC results out.
// Depends on ttcmr_pkg and the core; an internal predictor checks every result field.
module camera_ttc_median_ratio_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned POINT_DEPTH = 64;
    localparam int unsigned KEPT_DEPTH  = 4096;
    localparam int unsigned IDLE_LIMIT  = 3000000;
    localparam int unsigned ITEM_TARGET = 1250;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             start;
    logic                             busy;
    ttcmr_pkg::t_in                   i_in;
    ttcmr_pkg::t_out                  o_res;
    logic                             o_res_valid;
    logic                             i_cfg_valid;
    logic                             o_cfg_ready;
    logic [ttcmr_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [ttcmr_pkg::CFG_DATA_W-1:0] i_cfg_data;

    camera_ttc_median_ratio_core #(
        .MAX_MATCHES(POINT_DEPTH),
        .RATIO_DEPTH(KEPT_DEPTH)
    ) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_in(i_in), .o_res(o_res), .o_res_valid(o_res_valid),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    logic [ttcmr_pkg::PERIOD_W-1:0] model_period;
    logic [ttcmr_pkg::COORD_W-1:0]  model_min_dist;
    ttcmr_pkg::t_in                 point_mem [POINT_DEPTH];
    int unsigned                    point_cnt;
    ttcmr_pkg::t_out                ttc_expected [$];
    int unsigned                    mismatches;
    int unsigned                    items_sent;
    int unsigned                    sets_sent;
    int unsigned                    results_seen;
    int unsigned                    status_seen [4];
    int unsigned                    idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint unsigned isqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic logic [ttcmr_pkg::RATIO_W:0] dist_ratio(input longint unsigned sc,
                                                               input longint unsigned sp);
        longint unsigned q;
        longint unsigned r;
        longint unsigned v;
        q = sc / sp;
        r = sc % sp;
        if (q >= 64'd65536) return {1'b1, ttcmr_pkg::RATIO_MAX};
        for (int k = 0; k < 32; k++) begin
            r <<= 1;
            q <<= 1;
            if (r >= sp) begin
                r -= sp;
                q |= 64'd1;
            end
        end
        v = isqrt(q);
        if (v > 64'hFFFFFF) return {1'b1, ttcmr_pkg::RATIO_MAX};
        return {1'b0, v[ttcmr_pkg::RATIO_W-1:0]};
    endfunction

    function automatic longint unsigned sq_len(input logic [ttcmr_pkg::COORD_W-1:0] ax,
                                               input logic [ttcmr_pkg::COORD_W-1:0] ay,
                                               input logic [ttcmr_pkg::COORD_W-1:0] bx,
                                               input logic [ttcmr_pkg::COORD_W-1:0] by);
        longint unsigned dx;
        longint unsigned dy;
        dx = (ax > bx) ? ax - bx : bx - ax;
        dy = (ay > by) ? ay - by : by - ay;
        return dx * dx + dy * dy;
    endfunction

    function automatic bit predict_ttc(input ttcmr_pkg::t_in it, output ttcmr_pkg::t_out r);
        int unsigned     kept [$];
        longint unsigned sp;
        longint unsigned sc;
        longint unsigned min_sq;
        longint unsigned med;
        longint unsigned d;
        longint unsigned mag;
        longint          ttc;
        logic [ttcmr_pkg::RATIO_W:0] rr;
        bit              sat;
        int unsigned     n;
        r = '0;
        if (point_cnt < POINT_DEPTH) begin
            point_mem[point_cnt] = it;
            point_cnt++;
        end
        if (!it.last_match) return 1'b0;
        n = point_cnt;
        point_cnt = 0;
        sat = 1'b0;
        min_sq = longint'(model_min_dist) * longint'(model_min_dist);
        for (int i = 0; i + 1 < n; i++) begin
            for (int j = 1; j < n; j++) begin
                sp = sq_len(point_mem[i].prev_x, point_mem[i].prev_y,
                            point_mem[j].prev_x, point_mem[j].prev_y);
                sc = sq_len(point_mem[i].curr_x, point_mem[i].curr_y,
                            point_mem[j].curr_x, point_mem[j].curr_y);
                if (sp > 0 && sc >= min_sq) begin
                    rr = dist_ratio(sc, sp);
                    if (rr[ttcmr_pkg::RATIO_W]) sat = 1'b1;
                    if (kept.size() < KEPT_DEPTH)
                        kept.insert(kept.size(), rr[ttcmr_pkg::RATIO_W-1:0]);
                end
            end
        end
        if (kept.size() == 0) begin
            r.status = ttcmr_pkg::ST_NONE;
            return 1'b1;
        end
        kept.sort();
        if (kept.size() % 2 == 0)
            med = (longint'(kept[kept.size()/2 - 1]) + kept[kept.size()/2]) >> 1;
        else
            med = kept[kept.size()/2];
        r.median_ratio = med[ttcmr_pkg::RATIO_W-1:0];
        if (med == 64'd65536) begin
            r.status = ttcmr_pkg::ST_ONE;
            return 1'b1;
        end
        d = (med > 64'd65536) ? med - 64'd65536 : 64'd65536 - med;
        mag = (longint'(model_period) * 64'd65536 + d / 2) / d;
        ttc = (med > 64'd65536) ? longint'(mag) : -longint'(mag);
        r.ttc_us = ttc[ttcmr_pkg::TTC_W-1:0];
        r.status = sat ? ttcmr_pkg::ST_SAT : ttcmr_pkg::ST_OK;
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        ttcmr_pkg::t_out want;
        if (i_rst_n && o_res_valid) begin
            results_seen++;
            status_seen[o_res.status]++;
            if (ttc_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", o_res);
            end else begin
                want = ttc_expected.pop_front();
                if (want.ttc_us !== o_res.ttc_us || want.median_ratio !== o_res.median_ratio
                        || want.status !== o_res.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected ttc %0d ratio %h status %0d,",
                                  " got ttc %0d ratio %h status %0d"},
                                 want.ttc_us, want.median_ratio, want.status,
                                 o_res.ttc_us, o_res.median_ratio, o_res.status);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_res_valid || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_match(input ttcmr_pkg::t_in it);
        int unsigned     gap;
        ttcmr_pkg::t_out r;
        gap = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0) gap = 0;
        @(negedge i_clk);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in  = it;
        start = 1'b1;
        do @(posedge i_clk); while (busy);
        items_sent++;
        if (it.last_match) sets_sent++;
        if (predict_ttc(it, r)) ttc_expected.insert(ttc_expected.size(), r);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        start = 1'b0;
        while (ttc_expected.size() != 0 || busy) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [ttcmr_pkg::CFG_IDX_W-1:0] idx,
                             input int unsigned value);
        wait_drained();
        i_cfg_index = idx;
        i_cfg_data  = value[ttcmr_pkg::CFG_DATA_W-1:0];
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == ttcmr_pkg::CFG_PERIOD) model_period = value[ttcmr_pkg::PERIOD_W-1:0];
        else if (idx == ttcmr_pkg::CFG_MINDIST) model_min_dist = value[ttcmr_pkg::COORD_W-1:0];
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic ttcmr_pkg::t_in pt(input int unsigned px, input int unsigned py,
                                          input int unsigned cx, input int unsigned cy,
                                          input bit last);
        ttcmr_pkg::t_in it;
        it.prev_x = px[15:0];
        it.prev_y = py[15:0];
        it.curr_x = cx[15:0];
        it.curr_y = cy[15:0];
        it.last_match = last;
        return it;
    endfunction

    function automatic int unsigned clip16(input longint v);
        if (v < 0) return 0;
        if (v > 65535) return 65535;
        return int'(v);
    endfunction

    function automatic ttcmr_pkg::t_in scene_point(input int unsigned scale,
                                                   input int unsigned off, input bit last);
        int unsigned px;
        int unsigned py;
        px = $urandom_range(0, 20000);
        py = $urandom_range(0, 20000);
        return pt(px, py, clip16((longint'(px) * scale >> 16) + off + $urandom_range(0, 6)),
                  clip16((longint'(py) * scale >> 16) + off + $urandom_range(0, 6)), last);
    endfunction

    function automatic ttcmr_pkg::t_in noise_point(input bit last);
        ttcmr_pkg::t_in it;
        it.prev_x     = 16'($urandom);
        it.prev_y     = 16'($urandom);
        it.curr_x     = 16'($urandom);
        it.curr_y     = 16'($urandom);
        it.last_match = last;
        return it;
    endfunction

    task automatic send_scene(input int unsigned n, input int unsigned scale);
        int unsigned off;
        off = $urandom_range(0, 4000);
        for (int k = 0; k < n; k++) send_match(scene_point(scale, off, k == n - 1));
    endtask

    task automatic test_directed();
        write_reg(ttcmr_pkg::CFG_MINDIST, 0);
        send_match(pt(100, 100, 200, 200, 1'b1));
        send_match(pt(0, 0, 50, 50, 1'b0));
        send_match(pt(160, 0, 210, 50, 1'b0));
        send_match(pt(0, 320, 50, 370, 1'b1));
        send_match(pt(1000, 1000, 1000, 1000, 1'b0));
        send_match(pt(1000, 1000, 3000, 3000, 1'b1));
        send_match(pt(0, 0, 0, 0, 1'b0));
        send_match(pt(1, 0, 65535, 65535, 1'b0));
        send_match(pt(0, 1, 65535, 0, 1'b1));
        send_match(pt(65535, 65535, 65535, 65535, 1'b0));
        send_match(pt(0, 0, 0, 0, 1'b0));
        send_match(pt(65535, 0, 0, 65535, 1'b1));
        send_match(pt(1000, 1000, 900, 900, 1'b0));
        send_match(pt(3000, 1000, 2700, 900, 1'b0));
        send_match(pt(1000, 3000, 900, 2700, 1'b0));
        send_match(pt(4000, 4000, 3600, 3600, 1'b1));
        write_reg(ttcmr_pkg::CFG_MINDIST, 65535);
        send_match(pt(0, 0, 0, 0, 1'b0));
        send_match(pt(10, 10, 65535, 65535, 1'b1));
        write_reg(ttcmr_pkg::CFG_MINDIST, 1600);
    endtask

    task automatic test_config_extremes();
        int unsigned periods [4] = '{0, 1, 1000000, 100000};
        int unsigned dists [4]   = '{0, 65535, 800, 1600};
        for (int p = 0; p < 4; p++) begin
            write_reg(ttcmr_pkg::CFG_PERIOD, periods[p]);
            write_reg(ttcmr_pkg::CFG_MINDIST, dists[p]);
            send_scene(4, 72000);
            send_scene(3, 60000);
            send_scene(2, 65536);
        end
    endtask

    task automatic test_full_store();
        write_reg(ttcmr_pkg::CFG_MINDIST, 65535);
        for (int k = 0; k < POINT_DEPTH + 2; k++) send_match(noise_point(k == POINT_DEPTH + 1));
        write_reg(ttcmr_pkg::CFG_MINDIST, 1600);
    endtask

    task automatic test_random_sets();
        int unsigned n;
        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 30) == 0) begin
                if ($urandom_range(0, 1))
                    write_reg(ttcmr_pkg::CFG_PERIOD, $urandom_range(1, 1000000));
                else
                    write_reg(ttcmr_pkg::CFG_MINDIST, $urandom_range(0, 3000));
            end
            if ($urandom_range(0, 20) == 0) wait_drained();
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(2, 8);
            case ($urandom_range(0, 9))
                0: for (int k = 0; k < n; k++) send_match(noise_point($urandom_range(0, 3) == 0));
                1: for (int k = 0; k < n; k++) send_match(noise_point(k == n - 1));
                2: send_scene(n, 65536);
                default: send_scene(n, $urandom_range(50000, 90000));
            endcase
        end
        send_match(noise_point(1'b1));
    endtask

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_in = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = ttcmr_pkg::CFG_PERIOD;
        i_cfg_data = '0;
        model_period = ttcmr_pkg::PERIOD_RST;
        model_min_dist = ttcmr_pkg::MINDIST_RST;
        point_cnt = 0;
        mismatches = 0;
        items_sent = 0;
        sets_sent = 0;
        results_seen = 0;
        status_seen = '{default: 0};
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_config_extremes();
        test_full_store();
        test_random_sets();
        wait_drained();
        repeat (50) @(negedge i_clk);
        $display("sent %0d matches in %0d sets, checked %0d results", items_sent, sets_sent,
                 results_seen);
        $display("status mix ok/none/one/sat: %0d/%0d/%0d/%0d", status_seen[0], status_seen[1],
                 status_seen[2], status_seen[3]);
        if (mismatches == 0 && ttc_expected.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
